FILE: rtl/nacb_pkg.sv
// ----------------------------------------------------------------------------
// nacb_pkg: shared types and constants of the nearest atom color blend
// Holds the controller states, the command and status groups between the
// controller and the datapath, and fixed field widths.
// ----------------------------------------------------------------------------
package nacb_pkg;

  localparam int COORD_W    = 20;
  localparam int RAD_W      = 12;
  localparam int COLOR_W    = 8;
  localparam int ENTRY_W    = 3 * COORD_W + RAD_W + 3 * COLOR_W;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int SCORE_W    = 2 * DIFF_W;
  localparam int ROOT_W     = DIFF_W;
  localparam int ROOT_BIT_W = 5;
  localparam int WEIGHT_W   = 16;
  localparam int QUOT_W     = COLOR_W + 1;
  localparam int QBIT_W     = 4;

  localparam logic [31:0]         EXPQ       = 32'd4278222805;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 16'hFFFF;
  localparam logic [COLOR_W-1:0]  COLOR_FULL = 8'hFF;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_ROOT,
    ST_LOOK,
    ST_ACC,
    ST_DIV,
    ST_DONE
  } nacb_state_t;

  typedef struct packed {
    logic init_step;
    logic load_write;
    logic query_start;
    logic scan_step;
    logic root_step;
    logic look;
    logic acc;
    logic div_step;
    logic result_load;
  } nacb_cmd_t;

  typedef struct packed {
    logic init_last;
    logic scan_done;
    logic fill_zero;
    logic root_last;
    logic entry_last;
    logic div_last;
    logic out_free;
  } nacb_status_t;

endpackage

FILE: rtl/nacb_ram.sv
// ----------------------------------------------------------------------------
// nacb_ram: generic single write port RAM with a registered read
// One write and one read address per cycle.
// ----------------------------------------------------------------------------
module nacb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/nacb_ctrl.sv
// ----------------------------------------------------------------------------
// nacb_ctrl: sequencer of the nearest atom color blend
// Steps through table build, scan, roots, weighting, division and output.
// ----------------------------------------------------------------------------
module nacb_ctrl
  import nacb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         query,
  input  nacb_status_t status,
  output logic         in_ready,
  output nacb_cmd_t    cmd
);

  nacb_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: if (status.init_last) state_next = ST_IDLE;
      ST_IDLE: if (in_valid && query) state_next = ST_SCAN;
      ST_SCAN: begin
        if (status.scan_done) begin
          state_next = status.fill_zero ? ST_DONE : ST_ROOT;
        end
      end
      ST_ROOT: if (status.root_last) state_next = ST_LOOK;
      ST_LOOK: state_next = ST_ACC;
      ST_ACC:  state_next = status.entry_last ? ST_DIV : ST_ROOT;
      ST_DIV:  if (status.div_last) state_next = ST_DONE;
      ST_DONE: if (status.out_free) state_next = ST_IDLE;
      default: state_next = ST_INIT;
    endcase
  end

  always_comb begin
    in_ready        = (state == ST_IDLE);
    cmd             = '0;
    cmd.init_step   = (state == ST_INIT);
    cmd.load_write  = (state == ST_IDLE) && in_valid && !query;
    cmd.query_start = (state == ST_IDLE) && in_valid && query;
    cmd.scan_step   = (state == ST_SCAN);
    cmd.root_step   = (state == ST_ROOT);
    cmd.look        = (state == ST_LOOK);
    cmd.acc         = (state == ST_ACC);
    cmd.div_step    = (state == ST_DIV);
    cmd.result_load = (state == ST_DONE) && status.out_free;
  end

endmodule

FILE: rtl/nacb_dp.sv
// ----------------------------------------------------------------------------
// nacb_dp: datapath of the nearest atom color blend
// Atom table, weight table, scoring pipeline, sorted kept list, square root,
// weighted accumulation, shared divider and output register.
// ----------------------------------------------------------------------------
module nacb_dp
  import nacb_pkg::*;
#(
  parameter int MAX_ATOMS       = 64,
  parameter int NEAREST_KEPT    = 10,
  parameter int EXP_TABLE_DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  nacb_cmd_t                  cmd,
  output nacb_status_t               status,
  input  logic                       cfg_write,
  input  logic [6:0]                 atom_count,
  input  logic [5:0]                 atom_index,
  input  logic signed [COORD_W-1:0]  pos_x,
  input  logic signed [COORD_W-1:0]  pos_y,
  input  logic signed [COORD_W-1:0]  pos_z,
  input  logic [RAD_W-1:0]           atom_radius,
  input  logic [COLOR_W-1:0]         atom_red,
  input  logic [COLOR_W-1:0]         atom_green,
  input  logic [COLOR_W-1:0]         atom_blue,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [COLOR_W-1:0]         out_red,
  output logic [COLOR_W-1:0]         out_green,
  output logic [COLOR_W-1:0]         out_blue,
  output logic [3:0]                 neighbour_count
);

  localparam int AW    = MAX_ATOMS > 1 ? $clog2(MAX_ATOMS) : 1;
  localparam int CW    = $clog2(MAX_ATOMS + 1);
  localparam int KW    = $clog2(NEAREST_KEPT + 1);
  localparam int IW    = NEAREST_KEPT > 1 ? $clog2(NEAREST_KEPT) : 1;
  localparam int EW    = $clog2(EXP_TABLE_DEPTH);
  localparam int ACC_W = WEIGHT_W + COLOR_W + KW;
  localparam int SUM_W = WEIGHT_W + KW;
  localparam int NUM_W = ACC_W + 1;

  logic [6:0]                     count_reg;
  logic signed [COORD_W-1:0]      vx, vy, vz;
  logic [CW-1:0]                  n_lim, scan_cnt;
  logic                           issue;
  logic [AW-1:0]                  rd_addr;
  logic [ENTRY_W-1:0]             rd_data;
  logic                           wr_en;
  logic                           va, vb, vc, vd;
  logic [AW-1:0]                  idx_a, idx_b, idx_c, idx_d;
  logic [DIFF_W-1:0]              adx, ady, adz;
  logic [RAD_W-1:0]               rad_b;
  logic [SCORE_W-1:0]             sqx, sqy, sqz;
  logic [2*RAD_W-1:0]             r2_c;
  logic [SCORE_W-1:0]             score_d;
  logic [SCORE_W-1:0]             sum_c;
  logic [SCORE_W-1:0]             nscore [NEAREST_KEPT];
  logic [AW-1:0]                  nidx [NEAREST_KEPT];
  logic [KW-1:0]                  fill, pos_cnt;
  logic [IW-1:0]                  ent;
  logic [ROOT_W-1:0]              root, cand, dist0, diff;
  logic [ROOT_BIT_W-1:0]          rb;
  logic [SCORE_W-1:0]             cand_sq;
  logic                           wok;
  logic [EW-1:0]                  init_k;
  logic [WEIGHT_W-1:0]            w_cur;
  logic [48:0]                    w_prod;
  logic [WEIGHT_W-1:0]            w_rd, w_use;
  logic [ACC_W-1:0]               acc_r, acc_g, acc_b, acc_sel;
  logic [SUM_W-1:0]               wsum, wsum_next;
  logic [1:0]                     ch;
  logic [QBIT_W-1:0]              db;
  logic [NUM_W-1:0]               num, trial;
  logic [QUOT_W-1:0]              quot, quot_next;
  logic [COLOR_W-1:0]             res_r, res_g, res_b, res_c;
  logic signed [DIFF_W-1:0]       dx, dy, dz;

  // Atom table and weight table.
  assign wr_en   = cmd.load_write && (32'(atom_index) < MAX_ATOMS);
  assign issue   = cmd.scan_step && (scan_cnt < n_lim);
  assign rd_addr = cmd.look ? nidx[ent] : scan_cnt[AW-1:0];

  nacb_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ATOMS)) u_atom_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(atom_index)),
    .wr_data ({pos_x, pos_y, pos_z, atom_radius, atom_red, atom_green, atom_blue}),
    .rd_en   (issue || cmd.look),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign w_prod = 49'(w_cur) * 49'(EXPQ) + 49'(33'h080000000);
  assign diff   = (ent == '0) ? '0 : ((root >= dist0) ? root - dist0 : '0);

  nacb_ram #(.WIDTH(WEIGHT_W), .DEPTH(EXP_TABLE_DEPTH)) u_weight_ram (
    .clk     (clk),
    .wr_en   (cmd.init_step),
    .wr_addr (init_k),
    .wr_data (w_cur),
    .rd_en   (cmd.look),
    .rd_addr (diff[EW-1:0]),
    .rd_data (w_rd)
  );

  // Scoring pipeline.
  assign dx = $signed({rd_data[ENTRY_W-1], rd_data[ENTRY_W-1 -: COORD_W]})
            - $signed({vx[COORD_W-1], vx});
  assign dy = $signed({rd_data[ENTRY_W-COORD_W-1], rd_data[ENTRY_W-COORD_W-1 -: COORD_W]})
            - $signed({vy[COORD_W-1], vy});
  assign dz = $signed({rd_data[ENTRY_W-2*COORD_W-1],
                       rd_data[ENTRY_W-2*COORD_W-1 -: COORD_W]})
            - $signed({vz[COORD_W-1], vz});
  assign sum_c = sqx + sqy + sqz;

  always_ff @(posedge clk) begin
    idx_a   <= scan_cnt[AW-1:0];
    idx_b   <= idx_a;
    adx     <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    ady     <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    adz     <= dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);
    rad_b   <= rd_data[3*COLOR_W +: RAD_W];
    idx_c   <= idx_b;
    sqx     <= adx * adx;
    sqy     <= ady * ady;
    sqz     <= adz * adz;
    r2_c    <= rad_b * rad_b;
    idx_d   <= idx_c;
    score_d <= (sum_c > SCORE_W'(r2_c)) ? sum_c - SCORE_W'(r2_c) : '0;
  end

  // Stable insertion position: entries with a score not above the new one stay ahead.
  always_comb begin
    pos_cnt = '0;
    for (int j = 0; j < NEAREST_KEPT; j++) begin
      if ((KW'(j) < fill) && (nscore[j] <= score_d)) begin
        pos_cnt = pos_cnt + KW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (vd && (pos_cnt < KW'(NEAREST_KEPT))) begin
      for (int j = 0; j < NEAREST_KEPT; j++) begin
        if (KW'(j) == pos_cnt) begin
          nscore[j] <= score_d;
          nidx[j]   <= idx_d;
        end
      end
      for (int j = 1; j < NEAREST_KEPT; j++) begin
        if (KW'(j) > pos_cnt) begin
          nscore[j] <= nscore[j-1];
          nidx[j]   <= nidx[j-1];
        end
      end
    end
  end

  // Square root, one result bit per cycle.
  assign cand    = root | (ROOT_W'(1) << rb);
  assign cand_sq = cand * cand;

  // Weighted accumulation and division.
  assign w_use     = wok ? w_rd : '0;
  assign wsum_next = wsum + SUM_W'(w_use);

  always_comb begin
    unique case (ch)
      CH_RED:   acc_sel = acc_r;
      CH_GREEN: acc_sel = acc_g;
      default:  acc_sel = acc_b;
    endcase
  end

  assign trial     = NUM_W'(wsum) << db;
  assign quot_next = (num >= trial) ? (quot | (QUOT_W'(1) << db)) : quot;
  assign res_c     = (quot_next > QUOT_W'(COLOR_FULL)) ? COLOR_FULL : quot_next[COLOR_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      vx    <= pos_x;
      vy    <= pos_y;
      vz    <= pos_z;
      n_lim <= (32'(count_reg) > MAX_ATOMS) ? CW'(MAX_ATOMS) : CW'(count_reg);
    end
    if (cmd.look) begin
      wok <= (32'(diff) < EXP_TABLE_DEPTH);
      if (ent == '0) begin
        dist0 <= root;
      end
    end
    if (cmd.acc && status.entry_last) begin
      num  <= NUM_W'(acc_r + ACC_W'(w_use) * ACC_W'(rd_data[2*COLOR_W +: COLOR_W]))
            + NUM_W'(wsum_next >> 1);
      quot <= '0;
    end else if (cmd.div_step) begin
      if (db == '0) begin
        unique case (ch)
          CH_RED:   res_r <= res_c;
          CH_GREEN: res_g <= res_c;
          default:  res_b <= res_c;
        endcase
        num  <= ((ch == CH_RED) ? NUM_W'(acc_g) : NUM_W'(acc_b)) + NUM_W'(wsum >> 1);
        quot <= '0;
      end else begin
        if (num >= trial) begin
          num <= num - trial;
        end
        quot <= quot_next;
      end
    end
    if (cmd.result_load) begin
      out_red   <= status.fill_zero ? COLOR_FULL : res_r;
      out_green <= status.fill_zero ? COLOR_FULL : res_g;
      out_blue  <= status.fill_zero ? COLOR_FULL : res_b;
      neighbour_count <= 4'(fill);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count_reg <= '0;
      init_k    <= '0;
      w_cur     <= WEIGHT_ONE;
      scan_cnt  <= '0;
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      vd        <= 1'b0;
      fill      <= '0;
      ent       <= '0;
      root      <= '0;
      rb        <= ROOT_BIT_W'(ROOT_W - 1);
      acc_r     <= '0;
      acc_g     <= '0;
      acc_b     <= '0;
      wsum      <= '0;
      ch        <= CH_RED;
      db        <= QBIT_W'(COLOR_W);
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        count_reg <= atom_count;
      end
      if (cmd.init_step) begin
        init_k <= init_k + EW'(1);
        w_cur  <= w_prod[47:32];
      end
      va <= issue;
      vb <= va;
      vc <= vb;
      vd <= vc;
      if (issue) begin
        scan_cnt <= scan_cnt + CW'(1);
      end
      if (vd && (fill < KW'(NEAREST_KEPT))) begin
        fill <= fill + KW'(1);
      end
      if (cmd.root_step) begin
        if (cand_sq <= nscore[ent]) begin
          root <= cand;
        end
        if (rb != '0) begin
          rb <= rb - ROOT_BIT_W'(1);
        end
      end
      if (cmd.acc) begin
        acc_r <= acc_r + ACC_W'(w_use) * ACC_W'(rd_data[2*COLOR_W +: COLOR_W]);
        acc_g <= acc_g + ACC_W'(w_use) * ACC_W'(rd_data[COLOR_W +: COLOR_W]);
        acc_b <= acc_b + ACC_W'(w_use) * ACC_W'(rd_data[0 +: COLOR_W]);
        wsum  <= wsum_next;
        ent   <= ent + IW'(1);
        root  <= '0;
        rb    <= ROOT_BIT_W'(ROOT_W - 1);
        ch    <= CH_RED;
        db    <= QBIT_W'(COLOR_W);
      end
      if (cmd.div_step) begin
        if (db == '0) begin
          ch <= ch + 2'd1;
          db <= QBIT_W'(COLOR_W);
        end else begin
          db <= db - QBIT_W'(1);
        end
      end
      if (cmd.query_start) begin
        scan_cnt <= '0;
        fill     <= '0;
        ent      <= '0;
        root     <= '0;
        rb       <= ROOT_BIT_W'(ROOT_W - 1);
        acc_r    <= '0;
        acc_g    <= '0;
        acc_b    <= '0;
        wsum     <= '0;
      end
      if (cmd.result_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    status            = '0;
    status.init_last  = (init_k == EW'(EXP_TABLE_DEPTH - 1));
    status.scan_done  = (scan_cnt == n_lim) && !va && !vb && !vc && !vd;
    status.fill_zero  = (fill == '0);
    status.root_last  = (rb == '0);
    status.entry_last = ((KW'(ent) + KW'(1)) == fill);
    status.div_last   = (ch == CH_BLUE) && (db == '0);
    status.out_free   = !out_valid || out_ready;
  end

endmodule

FILE: rtl/nearest_atom_color_blend.sv
// ----------------------------------------------------------------------------
// nearest_atom_color_blend: color of a vertex from its nearest atoms
// Loads an atom table and blends the colors of the nearest atoms of a vertex.
// ----------------------------------------------------------------------------
// After reset the block builds its exp(-d/256) weight table, one entry per
// cycle, and accepts no item during that time; configuration writes are taken
// at any time. A load item leaves the block ready for the next item. A query
// scans min(atom_count, MAX_ATOMS) atoms through the single read port of the
// atom table, one per cycle, then for each kept atom runs a 21-bit square root,
// a table lookup and an accumulation, then three divisions, one per color
// channel, on a shared divider. The next item is accepted while the result
// waits in the output register.
// ----------------------------------------------------------------------------
module nearest_atom_color_blend
  import nacb_pkg::*;
#(
  parameter int MAX_ATOMS       = 64,
  parameter int NEAREST_KEPT    = 10,
  parameter int EXP_TABLE_DEPTH = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [6:0]                atom_count,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      mode,
  input  logic [5:0]                atom_index,
  input  logic signed [COORD_W-1:0] pos_x,
  input  logic signed [COORD_W-1:0] pos_y,
  input  logic signed [COORD_W-1:0] pos_z,
  input  logic [RAD_W-1:0]          atom_radius,
  input  logic [COLOR_W-1:0]        atom_red,
  input  logic [COLOR_W-1:0]        atom_green,
  input  logic [COLOR_W-1:0]        atom_blue,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [COLOR_W-1:0]        out_red,
  output logic [COLOR_W-1:0]        out_green,
  output logic [COLOR_W-1:0]        out_blue,
  output logic [3:0]                neighbour_count
);

  nacb_cmd_t    cmd;
  nacb_status_t status;

  assign cfg_ready = 1'b1;

  nacb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .query    (mode),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  nacb_dp #(
    .MAX_ATOMS       (MAX_ATOMS),
    .NEAREST_KEPT    (NEAREST_KEPT),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_write       (cfg_valid && cfg_ready),
    .atom_count      (atom_count),
    .atom_index      (atom_index),
    .pos_x           (pos_x),
    .pos_y           (pos_y),
    .pos_z           (pos_z),
    .atom_radius     (atom_radius),
    .atom_red        (atom_red),
    .atom_green      (atom_green),
    .atom_blue       (atom_blue),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .neighbour_count (neighbour_count)
  );

`ifndef NO_ASSERTIONS
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && mode) |=> !in_ready)
    else $error("Ready stayed high after a query transfer.");

  a_white_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (neighbour_count == 4'd0)) |->
    (out_red == COLOR_FULL && out_green == COLOR_FULL && out_blue == COLOR_FULL))
    else $error("A result without neighbours is not white.");

  a_kept_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(neighbour_count) <= NEAREST_KEPT))
    else $error("Neighbour count exceeds the kept list.");
`endif

endmodule
